>>> sv/ftt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftt_pkg
// Shared types and constants of the forward timeout tracker.
// ----------------------------------------------------------------------------
package ftt_pkg;

  localparam int NODE_W    = 8;
  localparam int PAYLOAD_W = 16;
  localparam int TIME_W    = 32;
  localparam int SLOT_W    = 3;
  localparam int KIND_W    = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [NODE_W-1:0] PARENT_RESET  = 8'd2;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000;
  localparam logic [TIME_W-1:0] T_MAX         = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam logic [0:0] REG_PARENT_NODE = 1'b0;
  localparam logic [0:0] REG_TIMEOUT_MS  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_IGNORED = 4'd0,
    KIND_STORED  = 4'd1,
    KIND_FULL    = 4'd2,
    KIND_CLEARED = 4'd3,
    KIND_LATE    = 4'd4,
    KIND_UNKNOWN = 4'd5,
    KIND_EXPIRED = 4'd6,
    KIND_WAITING = 4'd7,
    KIND_NONE    = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TIME,
    S_SCAN,
    S_NONE,
    S_STORE,
    S_FIND,
    S_MATCH,
    S_IGNORE
  } state_t;

  // classified input transaction
  typedef struct packed {
    logic                 is_tick;
    logic                 to_parent;
    logic                 from_parent;
    logic [PAYLOAD_W-1:0] payload;
    logic [TIME_W-1:0]    elapsed;
  } item_t;

  typedef struct packed {
    kind_t                kind;
    logic [SLOT_W-1:0]    slot;
    logic [PAYLOAD_W-1:0] payload;
    logic [TIME_W-1:0]    remaining;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage : ftt_pkg
`default_nettype wire

>>> sv/forward_timeout_tracker_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// forward_timeout_tracker_core
// Checks that messages sent to a parent node are forwarded in time.
// ----------------------------------------------------------------------------
// Messages to the parent take a free slot with a saturated deadline; messages
// from the parent are matched by payload against occupied slots; a tick
// advances time and reports on each occupied slot, freeing expired ones.
// Items enter a four-deep queue and a back-end sequencer runs them one at a
// time: a message is ignored, stored, matched, or stored then matched; a tick
// advances time, then scans slots from slot zero up to the highest occupied
// one, or reports none when no slot is occupied. The back end visits one slot
// per cycle while the output is not stalled. Results leave through an output
// register, so a stalled output holds only the back end while the queue keeps
// accepting input until it is full. ENTRIES ranges 1 to 8.
module forward_timeout_tracker_core #(
  parameter int ENTRIES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // src_node, dst_node, payload, elapsed_ms
  input  wire logic [0:0]  s_axis_tuser,  // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,  // slot, entry_payload, remaining_ms, zero fill
  output logic [3:0]       m_axis_tuser,  // kind
  output logic             m_axis_tlast,
  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import ftt_pkg::*;

  logic [NODE_W-1:0] parent_node;
  logic [TIME_W-1:0] timeout_ms;
  q_status_t         q_status;
  logic              push;
  item_t             push_item;
  logic              pop;
  item_t             head;
  result_t           out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      parent_node <= PARENT_RESET;
      timeout_ms  <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PARENT_NODE: parent_node <= cfg_data[NODE_W-1:0];
        REG_TIMEOUT_MS:  timeout_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  ftt_front u_front (
    .s_tvalid    (s_axis_tvalid),
    .s_tready    (s_axis_tready),
    .s_tdata     (s_axis_tdata),
    .s_tuser     (s_axis_tuser),
    .parent_node (parent_node),
    .q_status    (q_status),
    .push        (push),
    .push_item   (push_item)
  );

  ftt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  ftt_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .timeout_ms (timeout_ms),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_res    (out_res)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;
  assign m_axis_tdata = {5'd0, out_res.remaining, out_res.payload, out_res.slot};

  // back end only takes an item the queue actually holds
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // kinds without a slot report slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_IGNORED || m_axis_tuser == KIND_FULL ||
                      m_axis_tuser == KIND_UNKNOWN || m_axis_tuser == KIND_NONE)
    |-> (m_axis_tdata[2:0] == '0))
    else $error("slot set on slotless result");

  // remaining time only on waiting results
  a_remaining: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != KIND_WAITING) |-> (m_axis_tdata[50:19] == '0))
    else $error("remaining time on non-waiting result");

endmodule : forward_timeout_tracker_core
`default_nettype wire

>>> sv/ftt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftt_front
// Input side: takes stream transactions and classifies them against the
// parent node before they enter the queue.
// ----------------------------------------------------------------------------
module ftt_front (
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [63:0]               s_tdata,
  input  wire logic [0:0]                s_tuser,
  input  wire logic [ftt_pkg::NODE_W-1:0] parent_node,
  input  wire ftt_pkg::q_status_t        q_status,
  output logic                           push,
  output ftt_pkg::item_t                 push_item
);
  import ftt_pkg::*;

  logic [NODE_W-1:0] src_node;
  logic [NODE_W-1:0] dst_node;

  assign src_node = s_tdata[7:0];
  assign dst_node = s_tdata[15:8];

  assign s_tready = !q_status.full;
  assign push     = s_tvalid && !q_status.full;

  always_comb begin
    push_item.is_tick     = s_tuser[0];
    push_item.to_parent   = !s_tuser[0] && (dst_node == parent_node);
    push_item.from_parent = !s_tuser[0] && (src_node == parent_node);
    push_item.payload     = s_tdata[31:16];
    push_item.elapsed     = s_tdata[63:32];
  end

endmodule : ftt_front
`default_nettype wire

>>> sv/ftt_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftt_queue
// Short first-in first-out queue of classified items between the front and
// the back end.
// ----------------------------------------------------------------------------
module ftt_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire ftt_pkg::item_t push_item,
  input  wire logic           pop,
  output ftt_pkg::item_t      head,
  output ftt_pkg::q_status_t  status
);
  import ftt_pkg::*;

  item_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign head         = entries[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule : ftt_queue
`default_nettype wire

>>> sv/ftt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftt_back
// Back end: holds the slot table and the current time, carries out one item
// at a time and drives the registered result stream.
// ----------------------------------------------------------------------------
module ftt_back #(
  parameter int ENTRIES = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [ftt_pkg::TIME_W-1:0]  timeout_ms,
  input  wire ftt_pkg::item_t              head,
  input  wire ftt_pkg::q_status_t          q_status,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output ftt_pkg::result_t                 out_res
);
  import ftt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  state_t               state;
  state_t               state_next;
  item_t                item;
  logic [TIME_W-1:0]    current_time;
  logic [ENTRIES-1:0]   slot_valid;
  logic [PAYLOAD_W-1:0] slot_payload  [ENTRIES];
  logic [TIME_W-1:0]    slot_deadline [ENTRIES];
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     idx_next;
  logic                 hit_found;

  logic                 out_free;
  logic                 out_load;
  result_t              res;
  logic                 time_en;
  logic                 store_en;
  logic                 clear_en;
  logic                 find_en;

  logic [IDX_W-1:0]     free_idx;
  logic                 free_any;
  logic [IDX_W-1:0]     hit_idx;
  logic                 hit_any;
  logic                 more_above;
  logic                 last_idx;
  logic [TIME_W:0]      time_sum;
  logic [TIME_W:0]      dl_sum;
  logic [TIME_W-1:0]    new_time;
  logic [TIME_W-1:0]    new_deadline;
  logic [TIME_W-1:0]    idx_deadline;

  assign out_free = !out_valid || out_ready;

  assign time_sum     = {1'b0, current_time} + {1'b0, item.elapsed};
  assign new_time     = time_sum[TIME_W] ? T_MAX : time_sum[TIME_W-1:0];
  assign dl_sum       = {1'b0, current_time} + {1'b0, timeout_ms};
  assign new_deadline = dl_sum[TIME_W] ? T_MAX : dl_sum[TIME_W-1:0];
  assign idx_deadline = slot_deadline[idx];
  assign last_idx     = (idx == IDX_W'(ENTRIES - 1));

  // lowest free slot and lowest valid slot whose payload matches
  always_comb begin
    free_idx   = '0;
    hit_idx    = '0;
    more_above = 1'b0;
    for (int j = ENTRIES - 1; j >= 0; j--) begin
      if (!slot_valid[j]) begin
        free_idx = IDX_W'(j);
      end
      if (slot_valid[j] && (slot_payload[j] == item.payload)) begin
        hit_idx = IDX_W'(j);
      end
      if (slot_valid[j] && (IDX_W'(j) > idx)) begin
        more_above = 1'b1;
      end
    end
  end

  assign free_any = !(&slot_valid);

  always_comb begin
    hit_any = 1'b0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (slot_valid[j] && (slot_payload[j] == item.payload)) begin
        hit_any = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    pop           = 1'b0;
    out_load      = 1'b0;
    time_en       = 1'b0;
    store_en      = 1'b0;
    clear_en      = 1'b0;
    find_en       = 1'b0;
    res.kind      = KIND_IGNORED;
    res.slot      = '0;
    res.payload   = item.payload;
    res.remaining = '0;
    res.last      = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          priority if (head.is_tick) begin
            state_next = S_TIME;
          end else if (head.to_parent) begin
            state_next = S_STORE;
          end else if (head.from_parent) begin
            state_next = S_FIND;
          end else begin
            state_next = S_IGNORE;
          end
        end
      end
      S_TIME: begin
        time_en    = 1'b1;
        idx_next   = '0;
        state_next = (|slot_valid) ? S_SCAN : S_NONE;
      end
      S_SCAN: begin
        if (!slot_valid[idx]) begin
          if (last_idx || !more_above) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end else if (out_free) begin
          out_load    = 1'b1;
          res.slot    = SLOT_W'(idx);
          res.payload = slot_payload[idx];
          res.last    = !more_above;
          // current_time already holds the advanced value here
          if (idx_deadline <= current_time) begin
            res.kind = KIND_EXPIRED;
            clear_en = 1'b1;
          end else begin
            res.kind      = KIND_WAITING;
            res.remaining = idx_deadline - current_time;
          end
          if (!more_above) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      S_NONE: begin
        if (out_free) begin
          out_load    = 1'b1;
          res.kind    = KIND_NONE;
          res.payload = '0;
          state_next  = S_IDLE;
        end
      end
      S_STORE: begin
        if (out_free) begin
          out_load = 1'b1;
          res.last = !item.from_parent;
          if (free_any) begin
            store_en = 1'b1;
            res.kind = KIND_STORED;
            res.slot = SLOT_W'(free_idx);
          end else begin
            res.kind = KIND_FULL;
          end
          state_next = item.from_parent ? S_FIND : S_IDLE;
        end
      end
      S_FIND: begin
        // sees the slot that a store in S_STORE has just written
        find_en    = 1'b1;
        idx_next   = hit_idx;
        state_next = S_MATCH;
      end
      S_MATCH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (!hit_found) begin
            res.kind = KIND_UNKNOWN;
          end else if (idx_deadline < current_time) begin
            res.kind = KIND_LATE;
            res.slot = SLOT_W'(idx);
          end else begin
            res.kind = KIND_CLEARED;
            res.slot = SLOT_W'(idx);
            clear_en = 1'b1;
          end
        end
      end
      S_IGNORE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item <= head;
    end
    if (find_en) begin
      hit_found <= hit_any;
    end
    idx <= idx_next;
    if (store_en) begin
      slot_payload[free_idx]  <= item.payload;
      slot_deadline[free_idx] <= new_deadline;
    end
    if (out_load) begin
      out_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_time <= '0;
      slot_valid   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (time_en) begin
        current_time <= new_time;
      end
      if (store_en) begin
        slot_valid[free_idx] <= 1'b1;
      end
      if (clear_en) begin
        slot_valid[idx] <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule : ftt_back
`default_nettype wire

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for forward_timeout_tracker_core.
// ----------------------------------------------------------------------------
// Directed checks of the slot table (store, full, match, duplicate keys,
// expiry, register extremes, time saturation) and random message traffic in
// several phases of input gaps and output stalls. A behavioral copy of the
// tracker predicts every report; each output transaction is compared field
// by field with the oldest predicted report.
module testbench;
  import ftt_pkg::*;

  localparam int SLOTS = 8;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = SLOTS + 8;
  localparam int MAX_PRINTS = 100;
  localparam logic CMD_MSG = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // src_node, dst_node, payload, elapsed_ms
  logic [0:0] s_axis_tuser = '0;    // cmd
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // slot, entry_payload, remaining_ms, zero fill
  logic [3:0] m_axis_tuser;         // kind
  logic m_axis_tlast;
  logic cfg_wr_en = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // mirror of the tracker
  logic [NODE_W-1:0] parent_id;
  logic [TIME_W-1:0] forward_window;
  logic [TIME_W-1:0] now_ms;
  logic slot_live [SLOTS];
  logic [PAYLOAD_W-1:0] slot_key [SLOTS];
  logic [TIME_W-1:0] slot_due [SLOTS];

  result_t pending_reports [$];
  result_t oldest_report;
  int mismatch_count = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  forward_timeout_tracker_core #(.ENTRIES(SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, predicted %0h", what, got, want));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("unpredicted report, kind %0d", m_axis_tuser));
      end else begin
        oldest_report = pending_reports.pop_front();
        check_field("kind", 32'(m_axis_tuser), 32'(oldest_report.kind));
        check_field("slot", 32'(m_axis_tdata[2:0]), 32'(oldest_report.slot));
        check_field("entry_payload", 32'(m_axis_tdata[18:3]),
                    32'(oldest_report.payload));
        check_field("remaining_ms", m_axis_tdata[50:19], oldest_report.remaining);
        check_field("last", 32'(m_axis_tlast), 32'(oldest_report.last));
      end
    end
  end

  function automatic logic [TIME_W-1:0] sum_sat(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? T_MAX : s[TIME_W-1:0];
  endfunction

  function automatic result_t make_report(input kind_t k, input int idx,
                                          input logic [PAYLOAD_W-1:0] p,
                                          input logic [TIME_W-1:0] rem);
    result_t r;
    r.kind = k;
    r.slot = SLOT_W'(idx);
    r.payload = p;
    r.remaining = rem;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic clear_slot(input int i);
    slot_live[i] = 1'b0;
    slot_key[i] = '0;
    slot_due[i] = '0;
  endtask

  // predicts the reports of one accepted transaction and updates the table
  task automatic tracker_step(input logic cmd, input logic [NODE_W-1:0] src,
                              input logic [NODE_W-1:0] dst,
                              input logic [PAYLOAD_W-1:0] pay,
                              input logic [TIME_W-1:0] elapsed);
    result_t batch [$];
    int hit;
    int free_idx;
    hit = -1;
    free_idx = -1;
    if (cmd == CMD_MSG) begin
      if (dst == parent_id) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_live[i] && free_idx < 0) free_idx = i;
        end
        if (free_idx >= 0) begin
          slot_live[free_idx] = 1'b1;
          slot_key[free_idx] = pay;
          slot_due[free_idx] = sum_sat(now_ms, forward_window);
          batch.push_back(make_report(KIND_STORED, free_idx, pay, '0));
        end else begin
          batch.push_back(make_report(KIND_FULL, 0, pay, '0));
        end
      end
      // runs after the store, so a message to and from the parent can hit itself
      if (src == parent_id) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i] && slot_key[i] == pay && hit < 0) hit = i;
        end
        if (hit < 0) begin
          batch.push_back(make_report(KIND_UNKNOWN, 0, pay, '0));
        end else if (slot_due[hit] < now_ms) begin
          batch.push_back(make_report(KIND_LATE, hit, pay, '0));
        end else begin
          clear_slot(hit);
          batch.push_back(make_report(KIND_CLEARED, hit, pay, '0));
        end
      end
      if (batch.size() == 0) batch.push_back(make_report(KIND_IGNORED, 0, pay, '0));
    end else begin
      now_ms = sum_sat(now_ms, elapsed);
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_live[i]) begin
          if (slot_due[i] <= now_ms) begin
            batch.push_back(make_report(KIND_EXPIRED, i, slot_key[i], '0));
            clear_slot(i);
          end else begin
            batch.push_back(make_report(KIND_WAITING, i, slot_key[i],
                                        slot_due[i] - now_ms));
          end
        end
      end
      if (batch.size() == 0) batch.push_back(make_report(KIND_NONE, 0, '0, '0));
    end
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) pending_reports.push_back(batch[k]);
  endtask

  task automatic send_item(input logic cmd, input logic [NODE_W-1:0] src,
                           input logic [NODE_W-1:0] dst,
                           input logic [PAYLOAD_W-1:0] pay,
                           input logic [TIME_W-1:0] elapsed);
    @(negedge clk);
    s_axis_tuser <= cmd;
    s_axis_tdata <= {elapsed, pay, dst, src};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    tracker_step(cmd, src, dst, pay, elapsed);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // unused fields carry random bits
  task automatic send_msg(input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst,
                          input logic [PAYLOAD_W-1:0] pay);
    send_item(CMD_MSG, src, dst, pay, $urandom);
  endtask

  task automatic send_tick(input logic [TIME_W-1:0] elapsed);
    send_item(CMD_TICK, NODE_W'($urandom), NODE_W'($urandom), PAYLOAD_W'($urandom),
              elapsed);
  endtask

  // stop sending and let every predicted report drain
  task automatic settle_tracker();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [0:0] index, input logic [31:0] value);
    settle_tracker();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    if (index == REG_PARENT_NODE) begin
      parent_id = value[NODE_W-1:0];
    end else begin
      forward_window = value;
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_basic_flow();
    send_tick(32'd0);
    send_msg(8'd0, parent_id, 16'hFFFF);
    send_tick(32'd400);
    send_msg(parent_id, 8'd255, 16'hFFFF);
    send_msg(parent_id, 8'd0, 16'h1234);
    send_msg(8'd0, 8'd255, 16'h0000);
  endtask

  // duplicate keys sit in the two top slots so the lowest one must win
  task automatic test_full_table();
    for (int i = 0; i < SLOTS - 2; i++) send_msg(8'd1, parent_id, PAYLOAD_W'(i));
    send_msg(8'd1, parent_id, 16'h0055);
    send_msg(8'd1, parent_id, 16'h0055);
    send_msg(8'd1, parent_id, 16'h7777);
    send_msg(parent_id, parent_id, 16'h0055);
    send_tick(forward_window - 32'd1);
    send_tick(32'd1);
  endtask

  task automatic test_register_extremes();
    write_register(REG_PARENT_NODE, 32'd255);
    write_register(REG_TIMEOUT_MS, 32'd0);
    send_msg(8'd255, 8'd255, 16'h8000);
    send_msg(8'd0, 8'd255, 16'h7FFF);
    send_tick(32'd0);
    write_register(REG_PARENT_NODE, 32'd0);
    write_register(REG_TIMEOUT_MS, 32'hFFFF_FFFF);
    send_msg(8'd255, 8'd0, 16'hFFFF);
    send_tick(32'd5);
    send_msg(8'd0, 8'd255, 16'hFFFF);
  endtask

  function automatic logic [PAYLOAD_W-1:0] pick_payload();
    return ($urandom_range(0, 1) == 0) ? PAYLOAD_W'($urandom_range(0, 15))
                                       : PAYLOAD_W'($urandom);
  endfunction

  task automatic random_traffic(input int count);
    int live_idx [$];
    int roll;
    logic [PAYLOAD_W-1:0] pay;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      live_idx = {};
      for (int i = 0; i < SLOTS; i++) if (slot_live[i]) live_idx.push_back(i);
      if (live_idx.size() > 0 && $urandom_range(0, 4) != 0) begin
        pay = slot_key[live_idx[$urandom_range(0, live_idx.size() - 1)]];
      end else begin
        pay = pick_payload();
      end
      if (roll < 18) begin
        case ($urandom_range(0, 9))
          0: send_tick(32'd0);
          1, 2: send_tick($urandom_range(0, 3000));
          default: send_tick($urandom_range(0, 600));
        endcase
      end else if (roll < 50) begin
        send_msg(NODE_W'($urandom), parent_id, pick_payload());
      end else if (roll < 85) begin
        send_msg(parent_id, NODE_W'($urandom), pay);
      end else if (roll < 90) begin
        send_msg(parent_id, parent_id, pay);
      end else begin
        send_msg(NODE_W'($urandom), NODE_W'($urandom), PAYLOAD_W'($urandom));
      end
      // now and then hold off until the tracker has gone quiet
      if ($urandom_range(0, 39) == 0) settle_tracker();
    end
  endtask

  task automatic random_phase(input int gap, input int stall,
                              input logic [NODE_W-1:0] parent,
                              input logic [TIME_W-1:0] window, input int count);
    write_register(REG_PARENT_NODE, 32'(parent));
    write_register(REG_TIMEOUT_MS, window);
    idle_pct = gap;
    stall_pct = stall;
    random_traffic(count);
  endtask

  task automatic test_random_traffic();
    random_phase(0, 0, NODE_W'($urandom_range(3, 254)), 32'd1500, 75);
    random_phase(65, 0, 8'd0, $urandom_range(200, 800), 75);
    random_phase(0, 65, 8'd255, 32'd0, 75);
    random_phase(9, 9, NODE_W'($urandom), $urandom_range(500, 3000), 75);
    idle_pct = 0;
    stall_pct = 0;
  endtask

  // time runs into its ceiling, so this stays at the very end
  task automatic test_time_saturation();
    write_register(REG_TIMEOUT_MS, 32'd10);
    send_tick(32'hFFFF_FFFF);
    send_msg(8'd0, parent_id, 16'hA5A5);
    send_tick(32'd0);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("forward_timeout_tracker_core verification failed");
    $finish;
  end

  initial begin
    parent_id = PARENT_RESET;
    forward_window = TIMEOUT_RESET;
    now_ms = '0;
    for (int i = 0; i < SLOTS; i++) clear_slot(i);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_basic_flow();
    test_full_table();
    test_register_extremes();
    test_random_traffic();
    test_time_saturation();
    settle_tracker();
    if (mismatch_count == 0) begin
      $display("forward_timeout_tracker_core verification clean");
    end else begin
      $display("forward_timeout_tracker_core verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/ftt_pkg.sv
sv/ftt_front.sv
sv/ftt_queue.sv
sv/ftt_back.sv
sv/forward_timeout_tracker_core.sv
tb/sv/testbench.sv
